// ----- rtl/core/pfru_pkg.sv -----
// constants and register codes for the page frame replacement unit
`timescale 1ns / 1ps
package pfru_pkg;

    localparam int FRAMES               = 64;
    localparam int FRAME_IDX_W          = $clog2(FRAMES);
    localparam int FRAME_CNT_W          = $clog2(FRAMES + 1);
    localparam int PROC_W               = 3;
    localparam int PROCESSES            = 1 << PROC_W;
    localparam int VA_W                 = 32;
    localparam int PAGE_BITS            = 12;
    localparam int VPN_W                = VA_W - PAGE_BITS;
    localparam int FIRST_LEVEL_MAX_BITS = 10;
    localparam int FL_LIMIT             = (FIRST_LEVEL_MAX_BITS < VPN_W) ?
                                          FIRST_LEVEL_MAX_BITS : VPN_W;
    localparam int FL_W                 = 4;
    localparam int SHIFT_W              = $clog2(VPN_W + 1);
    localparam int STAMP_W              = 32;
    localparam int PA_W                 = FRAME_IDX_W + PAGE_BITS;
    localparam int TAG_W                = PROC_W + VPN_W;
    localparam int SLOT_ADDR_W          = PROC_W + FIRST_LEVEL_MAX_BITS;
    localparam int SLOT_DEPTH           = 1 << SLOT_ADDR_W;

    localparam int MODE_W               = 2;
    localparam int FCL_W                = 3;

    localparam int CFG_DATA_W           = 32;
    localparam int CFG_ADDR_W           = 4;
    localparam int CFG_IDX_W            = CFG_ADDR_W - 2;

    localparam logic [MODE_W-1:0] MODE_FIFO     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LRU      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LRU_SLOT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_POLICY_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT_LOG2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_LEVEL_BITS = 2'd2;

    localparam logic [MODE_W-1:0] POLICY_MODE_RST      = MODE_LRU;
    localparam logic [FCL_W-1:0]  FRAME_COUNT_LOG2_RST = 3'd6;
    localparam logic [FL_W-1:0]   FIRST_LEVEL_BITS_RST = 4'd10;

endpackage

// ----- rtl/core/page_frame_replacement_unit.sv -----
// page frame replacement unit: tag search, fifo or lru victim choice, slot tracking
//
// input channel in_valid/in_ready carries one item (proc_id, virtual_address);
// output channel out_valid/out_ready carries one result (hit, frame_index,
// physical_address, new_second_level). configuration goes over the apb port;
// the user must write it only while the block is idle, which is not enforced.
// one item is worked at a time by a sequencer:
// the tag search reads one frame per cycle from the tag memory, and on a full
// miss in lru mode a second pass reads one stamp per cycle to find the minimum.
// the search stops at the first free frame or hit among the frames in use, up
// to 64; on a full miss fifo mode takes the fifo frame and lru mode scans the
// stamps. in mode 2 a slot read and slot check follow on a fault, and every
// item then passes the write and done states.
// the result sits in an output register; the next item is accepted while it
// waits, and a new result is held back until the old one has been taken.
// after reset the slot store is cleared, one entry a cycle, while in_ready
// stays low. frame valid marks clear at once.
`timescale 1ns / 1ps
module page_frame_replacement_unit
    import pfru_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [PROC_W-1:0]      proc_id,
    input  logic [VA_W-1:0]        virtual_address,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   hit,
    output logic [FRAME_IDX_W-1:0] frame_index,
    output logic [PA_W-1:0]        physical_address,
    output logic                   new_second_level,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_ADDR_W-1:0]  paddr,
    input  logic [CFG_DATA_W-1:0]  pwdata,
    output logic [CFG_DATA_W-1:0]  prdata,
    output logic                   pready
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEARCH,
        ST_SCAN,
        ST_SLOT_RD,
        ST_SLOT_CHK,
        ST_WRITE,
        ST_DONE
    } state_t;

    state_t                 state_reg, state_next;

    logic [MODE_W-1:0]      policy_mode_reg;
    logic [FCL_W-1:0]       frame_count_log2_reg;
    logic [FL_W-1:0]        first_level_bits_reg;

    logic [PROC_W-1:0]      proc_reg, proc_next;
    logic [VPN_W-1:0]       vpn_reg, vpn_next;
    logic [PAGE_BITS-1:0]   offset_reg, offset_next;
    logic [FRAME_CNT_W-1:0] idx_reg, idx_next;
    logic                   pend_reg, pend_next;
    logic [FRAME_IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic [FRAME_IDX_W-1:0] frame_reg, frame_next;
    logic                   hit_reg, hit_next;
    logic                   newslot_reg, newslot_next;
    logic [STAMP_W-1:0]     best_reg, best_next;
    logic [SLOT_ADDR_W-1:0] clear_cnt_reg, clear_cnt_next;
    logic [FRAMES-1:0]      frame_valid_reg, frame_valid_next;
    logic [STAMP_W-1:0]     access_clock_reg, access_clock_next;
    logic [FRAME_IDX_W-1:0] fifo_ptr_reg, fifo_ptr_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_hit_reg, out_hit_next;
    logic [FRAME_IDX_W-1:0] out_frame_reg, out_frame_next;
    logic [PA_W-1:0]        out_pa_reg, out_pa_next;
    logic                   out_newslot_reg, out_newslot_next;

    logic [TAG_W-1:0]       tag_mem [FRAMES];
    logic [STAMP_W-1:0]     stamp_mem [FRAMES];
    logic                   slot_mem [SLOT_DEPTH];

    logic [TAG_W-1:0]       tag_rd_reg;
    logic [STAMP_W-1:0]     stamp_rd_reg;
    logic                   slot_rd_reg;

    logic                   tag_we;
    logic                   stamp_we;
    logic                   slot_we;
    logic [SLOT_ADDR_W-1:0] slot_wa;
    logic                   slot_wd;

    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_idx;
    logic [FCL_W-1:0]       fcl_eff;
    logic [FRAME_CNT_W-1:0] frames_n;
    logic [FRAME_IDX_W-1:0] last_idx;
    logic [FRAME_IDX_W-1:0] fifo_frame;
    logic [FL_W-1:0]        fl_eff;
    logic [SHIFT_W-1:0]     slot_shift;
    logic [VPN_W-1:0]       vpn_shifted;
    logic [SLOT_ADDR_W-1:0] slot_addr;
    logic                   issue;
    logic                   tag_match;
    logic                   post_slot;
    logic                   out_free;

    // apb configuration
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];

    always_comb
    begin
        case (cfg_idx)
            REG_POLICY_MODE:      prdata = CFG_DATA_W'(policy_mode_reg);
            REG_FRAME_COUNT_LOG2: prdata = CFG_DATA_W'(frame_count_log2_reg);
            REG_FIRST_LEVEL_BITS: prdata = CFG_DATA_W'(first_level_bits_reg);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_mode_reg      <= POLICY_MODE_RST;
            frame_count_log2_reg <= FRAME_COUNT_LOG2_RST;
            first_level_bits_reg <= FIRST_LEVEL_BITS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_POLICY_MODE:      policy_mode_reg      <= pwdata[MODE_W-1:0];
                REG_FRAME_COUNT_LOG2: frame_count_log2_reg <= pwdata[FCL_W-1:0];
                REG_FIRST_LEVEL_BITS: first_level_bits_reg <= pwdata[FL_W-1:0];
                default:              ;
            endcase
        end
    end

    // frames in use and slot index
    assign fcl_eff = (32'(frame_count_log2_reg) > FRAME_IDX_W) ?
                     FCL_W'(FRAME_IDX_W) : frame_count_log2_reg;
    assign frames_n   = FRAME_CNT_W'(1) << fcl_eff;
    assign last_idx   = FRAME_IDX_W'(frames_n - FRAME_CNT_W'(1));
    assign fifo_frame = fifo_ptr_reg & last_idx;

    always_comb
    begin
        if (first_level_bits_reg == '0)
            fl_eff = FL_W'(1);
        else if (32'(first_level_bits_reg) > FL_LIMIT)
            fl_eff = FL_W'(FL_LIMIT);
        else
            fl_eff = first_level_bits_reg;
    end

    assign slot_shift  = SHIFT_W'(VPN_W) - SHIFT_W'(fl_eff);
    assign vpn_shifted = vpn_reg >> slot_shift;
    assign slot_addr   = {proc_reg, vpn_shifted[FIRST_LEVEL_MAX_BITS-1:0]};

    assign issue     = (state_reg == ST_SEARCH || state_reg == ST_SCAN) &&
                       (idx_reg < frames_n);
    assign tag_match = (tag_rd_reg == {proc_reg, vpn_reg});
    assign post_slot = (policy_mode_reg == MODE_LRU_SLOT);
    assign out_free  = !out_valid_reg || out_ready;

    assign in_ready = (state_reg == ST_IDLE);

    // memory write controls
    assign tag_we   = (state_reg == ST_WRITE) && !hit_reg;
    assign stamp_we = (state_reg == ST_WRITE);

    always_comb
    begin
        slot_we = 1'b0;
        slot_wa = slot_addr;
        slot_wd = 1'b1;
        if (state_reg == ST_CLEAR)
        begin
            slot_we = 1'b1;
            slot_wa = clear_cnt_reg;
            slot_wd = 1'b0;
        end
        else if (state_reg == ST_SLOT_CHK && !slot_rd_reg)
        begin
            slot_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
            tag_mem[frame_reg] <= {proc_reg, vpn_reg};
        tag_rd_reg <= tag_mem[idx_reg[FRAME_IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (stamp_we)
            stamp_mem[frame_reg] <= access_clock_reg;
        stamp_rd_reg <= stamp_mem[idx_reg[FRAME_IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_wa] <= slot_wd;
        slot_rd_reg <= slot_mem[slot_addr];
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        proc_next         = proc_reg;
        vpn_next          = vpn_reg;
        offset_next       = offset_reg;
        idx_next          = idx_reg;
        pend_next         = 1'b0;
        pend_idx_next     = idx_reg[FRAME_IDX_W-1:0];
        frame_next        = frame_reg;
        hit_next          = hit_reg;
        newslot_next      = newslot_reg;
        best_next         = best_reg;
        clear_cnt_next    = clear_cnt_reg;
        frame_valid_next  = frame_valid_reg;
        access_clock_next = access_clock_reg;
        fifo_ptr_next     = fifo_ptr_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_hit_next      = out_hit_reg;
        out_frame_next    = out_frame_reg;
        out_pa_next       = out_pa_reg;
        out_newslot_next  = out_newslot_reg;

        if (issue)
        begin
            pend_next = 1'b1;
            idx_next  = idx_reg + FRAME_CNT_W'(1);
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clear_cnt_next = clear_cnt_reg + SLOT_ADDR_W'(1);
                if (clear_cnt_reg == SLOT_ADDR_W'(SLOT_DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    proc_next    = proc_id;
                    vpn_next     = virtual_address[VA_W-1:PAGE_BITS];
                    offset_next  = virtual_address[PAGE_BITS-1:0];
                    idx_next     = '0;
                    hit_next     = 1'b0;
                    newslot_next = 1'b0;
                    state_next   = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (pend_reg)
                begin
                    if (!frame_valid_reg[pend_idx_reg])
                    begin
                        frame_next = pend_idx_reg;
                        state_next = post_slot ? ST_SLOT_RD : ST_WRITE;
                    end
                    else if (tag_match)
                    begin
                        frame_next = pend_idx_reg;
                        hit_next   = 1'b1;
                        state_next = ST_WRITE;
                    end
                    else if (pend_idx_reg == last_idx)
                    begin
                        if (policy_mode_reg == MODE_FIFO)
                        begin
                            frame_next    = fifo_frame;
                            fifo_ptr_next = (fifo_frame + FRAME_IDX_W'(1)) & last_idx;
                            state_next    = post_slot ? ST_SLOT_RD : ST_WRITE;
                        end
                        else
                        begin
                            frame_next = '0;
                            best_next  = access_clock_reg;
                            idx_next   = '0;
                            pend_next  = 1'b0;
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (pend_reg)
                begin
                    if (stamp_rd_reg < best_reg)
                    begin
                        best_next  = stamp_rd_reg;
                        frame_next = pend_idx_reg;
                    end
                    if (pend_idx_reg == last_idx)
                        state_next = post_slot ? ST_SLOT_RD : ST_WRITE;
                end
            end
            ST_SLOT_RD:
            begin
                state_next = ST_SLOT_CHK;
            end
            ST_SLOT_CHK:
            begin
                newslot_next = !slot_rd_reg;
                state_next   = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (!hit_reg)
                    frame_valid_next[frame_reg] = 1'b1;
                access_clock_next = access_clock_reg + STAMP_W'(1);
                state_next        = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_hit_next     = hit_reg;
                    out_frame_next   = frame_reg;
                    out_pa_next      = {frame_reg, offset_reg};
                    out_newslot_next = newslot_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            pend_reg         <= 1'b0;
            idx_reg          <= '0;
            clear_cnt_reg    <= '0;
            frame_valid_reg  <= '0;
            access_clock_reg <= STAMP_W'(1);
            fifo_ptr_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            pend_reg         <= pend_next;
            idx_reg          <= idx_next;
            clear_cnt_reg    <= clear_cnt_next;
            frame_valid_reg  <= frame_valid_next;
            access_clock_reg <= access_clock_next;
            fifo_ptr_reg     <= fifo_ptr_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        proc_reg        <= proc_next;
        vpn_reg         <= vpn_next;
        offset_reg      <= offset_next;
        pend_idx_reg    <= pend_idx_next;
        frame_reg       <= frame_next;
        hit_reg         <= hit_next;
        newslot_reg     <= newslot_next;
        best_reg        <= best_next;
        out_hit_reg     <= out_hit_next;
        out_frame_reg   <= out_frame_next;
        out_pa_reg      <= out_pa_next;
        out_newslot_reg <= out_newslot_next;
    end

    assign out_valid        = out_valid_reg;
    assign hit              = out_hit_reg;
    assign frame_index      = out_frame_reg;
    assign physical_address = out_pa_reg;
    assign new_second_level = out_newslot_reg;

    // checks
    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("item accepted while another is in progress");

    a_hit_no_new_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && hit) |-> !new_second_level)
        else $error("new slot flagged on a hit");

    a_new_slot_mode: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid) && new_second_level) |-> (policy_mode_reg == MODE_LRU_SLOT))
        else $error("new slot flagged outside slot tracking mode");

    a_clock_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |=>
            (access_clock_reg == $past(access_clock_reg) + STAMP_W'(1)))
        else $error("access clock did not advance by one");

    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (!in_ready && !out_valid))
        else $error("input taken during slot clearing");

endmodule
